// ===== rtl/core/evm_pkg.sv =====
// Package with the shared constants, types and arctangent table of the view matrix unit.
`default_nettype none
package evm_pkg;
    localparam int CORDIC_STEPS = 30;
    localparam int ZW = 34;
    localparam int XW = 34;
    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef logic signed [XW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        zval_t z;
        logic [1:0] quad;
    } rot_t;

    function automatic zval_t atan_turn(input int i);
        zval_t r;
        case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/euler_view_matrix_unit.sv =====
// Top level of the Euler-angle view matrix unit: trig chains, matrix pipeline and handshake.
//
//   channel  direction  handshake       payload
//   in       to unit    valid / stall   pitch/yaw/roll angles, pos_x/y/z
//   out      from unit  valid / stall   m00..m22, tx, ty, tz
//
// One item is accepted per cycle while the output is not stalled; from acceptance to output an item passes
// the 30-cell CORDIC chain, its rounding register and five matrix stages.
// The whole pipeline advances together and holds when the output is stalled.
// Reset clears only the valid bits of the pipeline.
`default_nettype none
module euler_view_matrix_unit #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [15:0] roll_angle,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      m00,
    output logic signed [15:0]      m01,
    output logic signed [15:0]      m02,
    output logic signed [15:0]      m10,
    output logic signed [15:0]      m11,
    output logic signed [15:0]      m12,
    output logic signed [15:0]      m20,
    output logic signed [15:0]      m21,
    output logic signed [15:0]      m22,
    output logic signed [31:0]      tx,
    output logic signed [31:0]      ty,
    output logic signed [31:0]      tz
);
    localparam int TRIG_LAT = evm_pkg::CORDIC_STEPS + 1;
    localparam int LAT = TRIG_LAT + 5;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic signed [TRIG_FRAC_BITS:0] sx, cx, sy, cy, sz, cz;
    logic signed [31:0] pd_reg [0:TRIG_LAT-1][0:2];
    logic signed [15:0] m_out [0:8];
    logic signed [31:0] t_out [0:2];

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg[0][0] <= pos_x;
            pd_reg[0][1] <= pos_y;
            pd_reg[0][2] <= pos_z;
            for (int s = 1; s < TRIG_LAT; s++)
            begin
                pd_reg[s] <= pd_reg[s-1];
            end
        end
    end

    evm_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sc_x (
        .clk(clk), .en(en), .angle(pitch_angle), .sin_val(sx), .cos_val(cx)
    );
    evm_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sc_y (
        .clk(clk), .en(en), .angle(yaw_angle), .sin_val(sy), .cos_val(cy)
    );
    evm_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sc_z (
        .clk(clk), .en(en), .angle(roll_angle), .sin_val(sz), .cos_val(cz)
    );

    evm_matrix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_matrix (
        .clk(clk), .en(en),
        .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
        .px(pd_reg[TRIG_LAT-1][0]), .py(pd_reg[TRIG_LAT-1][1]), .pz(pd_reg[TRIG_LAT-1][2]),
        .m_out(m_out), .t_out(t_out)
    );

    assign m00 = m_out[0];
    assign m01 = m_out[1];
    assign m02 = m_out[2];
    assign m10 = m_out[3];
    assign m11 = m_out[4];
    assign m12 = m_out[5];
    assign m20 = m_out[6];
    assign m21 = m_out[7];
    assign m22 = m_out[8];
    assign tx = t_out[0];
    assign ty = t_out[1];
    assign tz = t_out[2];

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tx) && $stable(m00))
        else $error("output changed while stalled");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> vld_reg[0] == $past(in_valid))
        else $error("pipeline lost an item at entry");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/evm_cordic_cell.sv =====
// One CORDIC rotation cell of the sine and cosine chain, with its own pipeline register.
`default_nettype none
module evm_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire evm_pkg::rot_t din,
    output evm_pkg::rot_t      dout
);
    evm_pkg::rot_t dout_reg;
    evm_pkg::rot_t dout_next;
    evm_pkg::cval_t dx;
    evm_pkg::cval_t dy;

    always_comb
    begin
        dx = din.y >>> STEP;
        dy = din.x >>> STEP;
        dout_next.quad = din.quad;
        if (!din.z[evm_pkg::ZW-1])
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - evm_pkg::atan_turn(STEP);
        end
        else
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + evm_pkg::atan_turn(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

// ===== rtl/core/evm_sincos.sv =====
// Chain of CORDIC cells giving the rounded sine and cosine of one binary angle.
`default_nettype none
module evm_sincos #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [15:0]                        angle,
    output logic signed [TRIG_FRAC_BITS:0]          sin_val,
    output logic signed [TRIG_FRAC_BITS:0]          cos_val
);
    localparam int N = evm_pkg::CORDIC_STEPS;
    localparam int SH = 30 - TRIG_FRAC_BITS;

    evm_pkg::rot_t chain [0:N];
    logic [31:0] phase;
    logic [47:0] ang_wide;
    evm_pkg::cval_t cv;
    evm_pkg::cval_t sv;
    logic signed [TRIG_FRAC_BITS:0] sin_next;
    logic signed [TRIG_FRAC_BITS:0] cos_next;
    logic signed [TRIG_FRAC_BITS:0] sin_reg;
    logic signed [TRIG_FRAC_BITS:0] cos_reg;

    function automatic logic signed [TRIG_FRAC_BITS:0] round_q30(input evm_pkg::cval_t v);
        evm_pkg::cval_t r;
        r = (v + (evm_pkg::cval_t'(1) <<< (SH - 1))) >>> SH;
        if (r > evm_pkg::cval_t'((1 <<< TRIG_FRAC_BITS) - 1))
            return {1'b0, {TRIG_FRAC_BITS{1'b1}}};
        else if (r < -evm_pkg::cval_t'(1 <<< TRIG_FRAC_BITS))
            return {1'b1, {TRIG_FRAC_BITS{1'b0}}};
        else
            return r[TRIG_FRAC_BITS:0];
    endfunction

    always_comb
    begin
        ang_wide = {32'd0, angle} & ((48'd1 << ANGLE_BITS) - 48'd1);
        phase = ang_wide[31:0] << (32 - ANGLE_BITS);
        chain[0].x = evm_pkg::GAIN_Q30;
        chain[0].y = '0;
        chain[0].z = evm_pkg::zval_t'({4'd0, phase[29:0]});
        chain[0].quad = phase[31:30];
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        evm_cordic_cell #(.STEP(i)) u_cell (
            .clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1])
        );
    end

    always_comb
    begin
        case (chain[N].quad)
            2'd0:
            begin
                cv = chain[N].x;
                sv = chain[N].y;
            end
            2'd1:
            begin
                cv = -chain[N].y;
                sv = chain[N].x;
            end
            2'd2:
            begin
                cv = -chain[N].x;
                sv = -chain[N].y;
            end
            default:
            begin
                cv = chain[N].y;
                sv = -chain[N].x;
            end
        endcase
        sin_next = round_q30(sv);
        cos_next = round_q30(cv);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;
endmodule
`default_nettype wire

// ===== rtl/core/evm_matrix.sv =====
// Pipelined products, rotation entries and translation row of the view matrix.
`default_nettype none
module evm_matrix #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [TRIG_FRAC_BITS:0] sx,
    input  wire logic signed [TRIG_FRAC_BITS:0] cx,
    input  wire logic signed [TRIG_FRAC_BITS:0] sy,
    input  wire logic signed [TRIG_FRAC_BITS:0] cy,
    input  wire logic signed [TRIG_FRAC_BITS:0] sz,
    input  wire logic signed [TRIG_FRAC_BITS:0] cz,
    input  wire logic signed [31:0]            px,
    input  wire logic signed [31:0]            py,
    input  wire logic signed [31:0]            pz,
    output logic signed [15:0]                 m_out [0:8],
    output logic signed [31:0]                 t_out [0:2]
);
    localparam int F = TRIG_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int PW = 2 * TW;
    localparam int SW = TW + 2;
    localparam int DW = TW + 33;
    localparam int AW = DW + 2;

    typedef logic signed [TW-1:0] trig_t;
    typedef logic signed [TW:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [DW-1:0] dot_t;
    typedef logic signed [AW-1:0] acc_t;

    // A product of two minus ones rounds to plus one, so products keep one extra bit.
    function automatic prod_t fmul(input prod_t a, input prod_t b);
        logic signed [PW:0] p;
        p = (PW+1)'(a) * (PW+1)'(b) + ((PW+1)'(1) <<< (F - 1));
        p = p >>> F;
        return p[TW:0];
    endfunction

    function automatic trig_t tsat(input sum_t v);
        if (v > sum_t'((1 <<< F) - 1))
            return {1'b0, {F{1'b1}}};
        else if (v < -sum_t'(1 <<< F))
            return {1'b1, {F{1'b0}}};
        else
            return v[TW-1:0];
    endfunction

    // Stage one: pairwise products of yaw and roll.
    prod_t cc_reg, cs_reg, sc_reg, ss_reg;
    trig_t sx1_reg, cx1_reg, sy1_reg, cy1_reg, sz1_reg, cz1_reg;
    logic signed [32:0] p1_reg [0:2];
    // Stage two: products with pitch.
    prod_t a_reg [0:3];
    prod_t cc2_reg, cs2_reg, sc2_reg, ss2_reg;
    trig_t m2_reg, m3_reg, m4_reg, m5_reg, m8_reg;
    logic signed [32:0] p2_reg [0:2];
    // Stage three: saturated entries.
    trig_t m_reg [0:8];
    logic signed [32:0] p3_reg [0:2];
    // Stage four: single products.
    dot_t d_reg [0:8];
    // Stage five: rounded and saturated translation.
    logic signed [31:0] t_reg [0:2];
    trig_t m4s_reg [0:8];
    trig_t m5s_reg [0:8];

    acc_t acc_next [0:2];
    logic signed [31:0] t_next [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg <= fmul(prod_t'(cy), prod_t'(cz));
            cs_reg <= fmul(prod_t'(cy), prod_t'(sz));
            sc_reg <= fmul(prod_t'(sy), prod_t'(cz));
            ss_reg <= fmul(prod_t'(sy), prod_t'(sz));
            sx1_reg <= sx;
            cx1_reg <= cx;
            sy1_reg <= sy;
            cy1_reg <= cy;
            sz1_reg <= sz;
            cz1_reg <= cz;
            p1_reg[0] <= -33'(px);
            p1_reg[1] <= -33'(py);
            p1_reg[2] <= -33'(pz);

            a_reg[0] <= fmul(ss_reg, prod_t'(sx1_reg));
            a_reg[1] <= fmul(sc_reg, prod_t'(sx1_reg));
            a_reg[2] <= fmul(cs_reg, prod_t'(sx1_reg));
            a_reg[3] <= fmul(cc_reg, prod_t'(sx1_reg));
            cc2_reg <= cc_reg;
            cs2_reg <= cs_reg;
            sc2_reg <= sc_reg;
            ss2_reg <= ss_reg;
            m2_reg <= tsat(sum_t'(fmul(prod_t'(cx1_reg), prod_t'(sy1_reg))));
            m3_reg <= tsat(sum_t'(fmul(prod_t'(cx1_reg), prod_t'(sz1_reg))));
            m4_reg <= tsat(sum_t'(fmul(prod_t'(cx1_reg), prod_t'(cz1_reg))));
            m5_reg <= tsat(-sum_t'(sx1_reg));
            m8_reg <= tsat(sum_t'(fmul(prod_t'(cy1_reg), prod_t'(cx1_reg))));
            p2_reg <= p1_reg;

            m_reg[0] <= tsat(sum_t'(cc2_reg) + sum_t'(a_reg[0]));
            m_reg[1] <= tsat(sum_t'(a_reg[1]) - sum_t'(cs2_reg));
            m_reg[2] <= m2_reg;
            m_reg[3] <= m3_reg;
            m_reg[4] <= m4_reg;
            m_reg[5] <= m5_reg;
            m_reg[6] <= tsat(sum_t'(a_reg[2]) - sum_t'(sc2_reg));
            m_reg[7] <= tsat(sum_t'(a_reg[3]) + sum_t'(ss2_reg));
            m_reg[8] <= m8_reg;
            p3_reg <= p2_reg;

            for (int k = 0; k < 9; k++)
            begin
                d_reg[k] <= dot_t'(m_reg[k]) * dot_t'(p3_reg[k / 3]);
            end
            m4s_reg <= m_reg;

            t_reg <= t_next;
            m5s_reg <= m4s_reg;
        end
    end

    // d_reg[k] holds entry k times the negated position component of its row.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            acc_next[j] = acc_t'(d_reg[j]) + acc_t'(d_reg[j+3]) + acc_t'(d_reg[j+6])
                + (acc_t'(1) <<< (F - 1));
            acc_next[j] = acc_next[j] >>> F;
            if (acc_next[j] > acc_t'(32'sh7fffffff))
                t_next[j] = 32'sh7fffffff;
            else if (acc_next[j] < -acc_t'(33'sh080000000))
                t_next[j] = 32'sh80000000;
            else
                t_next[j] = acc_next[j][31:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_out[k] = 16'(m5s_reg[k]);
        end
        t_out = t_reg;
    end
endmodule
`default_nettype wire
